[sv/lkvc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared sizes, codes and beat types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // Store geometry.
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int AGE_W       = IDX_W;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Operation codes carried in the func field.
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // One input beat.
    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] data;
    } t_out_item;

    // Per-entry storage views.
    typedef logic [MAX_ENTRIES-1:0]                  t_valid_vec;
    typedef logic [MAX_ENTRIES-1:0][KEY_W-1:0]       t_key_arr;
    typedef logic [MAX_ENTRIES-1:0][VAL_W-1:0]       t_val_arr;
    typedef logic [MAX_ENTRIES-1:0][AGE_W-1:0]       t_age_arr;

    // Lookup results handed from the match unit to the update logic.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] free_idx;
        logic [IDX_W-1:0] victim_idx;
    } t_lookup;

endpackage
`default_nettype wire

[sv/lkvc_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache lookup
// Parallel key match, first free slot and least recent entry selection.
// ----------------------------------------------------------------------------
module lkvc_lookup (
    input  wire logic [lkvc_pkg::KEY_W-1:0] i_key,
    input  wire lkvc_pkg::t_valid_vec       i_valid,
    input  wire lkvc_pkg::t_key_arr         i_keys,
    input  wire lkvc_pkg::t_age_arr         i_ages,
    input  wire logic [lkvc_pkg::CNT_W-1:0] i_count,
    output lkvc_pkg::t_lookup               o_lookup
);
    import lkvc_pkg::*;

    logic [CNT_W-1:0] oldest_age;

    // The least recent valid entry always carries age count-1.
    assign oldest_age = CNT_W'(i_count - CNT_W'(1));

    // Priority encoders; the lowest index wins, scanned from the top down.
    always_comb begin
        o_lookup = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_keys[i] == i_key)) begin
                o_lookup.hit     = 1'b1;
                o_lookup.hit_idx = IDX_W'(i);
            end
            if (!i_valid[i]) begin
                o_lookup.free_idx = IDX_W'(i);
            end
            if (i_valid[i] && (CNT_W'(i_ages[i]) == oldest_age)) begin
                o_lookup.victim_idx = IDX_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

[sv/lru_key_value_cache.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Path: a get beat goes from the input register to the result register.
// Throughput: one beat per cycle while the result channel does not stall; a
// get waits in the input register while a full result register is stalled.
// The match and age update are combinational. A put produces no result beat.
// Reset: synchronous, active low; clears all valid bits, ages, the entry
// count and the pipeline, and sets capacity to 16. No clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Request channel.
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire lkvc_pkg::t_in_item          i_in,
    // Result channel.
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output lkvc_pkg::t_out_item              o_out,
    // Capacity write channel.
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [lkvc_pkg::CAP_W-1:0]  i_cfg_data
);
    import lkvc_pkg::*;

    // Pipeline registers.
    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;

    // Store state.
    t_valid_vec       r_valid, n_valid;
    t_key_arr         r_keys,  n_keys;
    t_val_arr         r_vals,  n_vals;
    t_age_arr         r_ages,  n_ages;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CAP_W-1:0] r_capacity;

    t_lookup          lookup;
    logic [CNT_W-1:0] eff_cap;
    logic             out_free;
    logic             execute;
    logic             produce;
    logic             evict;
    logic [IDX_W-1:0] sel_idx;
    logic [AGE_W-1:0] sel_age;
    logic             age_all;
    logic             do_touch;

    assign o_cfg_ready = 1'b1;

    // Effective capacity, clamped to the range one to MAX_ENTRIES.
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(r_capacity) > MAX_ENTRIES) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CNT_W'(r_capacity);
        end
    end

    // Match unit.
    lkvc_lookup u_lookup (
        .i_key    (r_in.key),
        .i_valid  (r_valid),
        .i_keys   (r_keys),
        .i_ages   (r_ages),
        .i_count  (r_count),
        .o_lookup (lookup)
    );

    // A put never needs the result register, so it executes regardless.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign execute    = r_in_valid && ((r_in.func == FUNC_PUT) || out_free);
    assign produce    = execute && (r_in.func == FUNC_GET);
    assign o_in_stall = r_in_valid && !execute;
    assign evict      = (r_in.func == FUNC_PUT) && !lookup.hit && (r_count >= eff_cap);

    // Pick the slot that becomes most recent and its old age.
    always_comb begin
        sel_idx  = lookup.hit_idx;
        sel_age  = r_ages[lookup.hit_idx];
        age_all  = 1'b0;
        do_touch = lookup.hit;
        if (r_in.func == FUNC_PUT && !lookup.hit) begin
            do_touch = 1'b1;
            if (evict) begin
                sel_idx = lookup.victim_idx;
                sel_age = r_ages[lookup.victim_idx];
            end else begin
                sel_idx = lookup.free_idx;
                age_all = 1'b1;
            end
        end
    end

    // Next store state.
    always_comb begin
        n_valid = r_valid;
        n_keys  = r_keys;
        n_vals  = r_vals;
        n_ages  = r_ages;
        n_count = r_count;
        if (execute && do_touch) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (r_valid[i] && (IDX_W'(i) != sel_idx)
                        && (age_all || (r_ages[i] < sel_age))) begin
                    n_ages[i] = AGE_W'(r_ages[i] + AGE_W'(1));
                end
            end
            n_ages[sel_idx] = '0;
            if (r_in.func == FUNC_PUT) begin
                n_vals[sel_idx] = r_in.value;
                if (!lookup.hit) begin
                    n_keys[sel_idx] = r_in.key;
                end
                if (age_all) begin
                    n_valid[sel_idx] = 1'b1;
                    n_count          = CNT_W'(r_count + CNT_W'(1));
                end
            end
        end
    end

    // Control state and registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_ages      <= '0;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_valid <= n_valid;
            r_ages  <= n_ages;
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in;
        end
        if (produce) begin
            r_out.hit  <= lookup.hit;
            r_out.data <= lookup.hit ? r_vals[lookup.hit_idx] : '0;
        end
        r_keys <= n_keys;
        r_vals <= n_vals;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire
